### hw/rtl/rmi_pkg.sv
// Shared types for the running median insertion block.
// Holds the request, response and cell link structs; depends on nothing.
package rmi_pkg;

   localparam int SAMPLE_W = 32;
   localparam int COUNT_OUT_W = 7;

   typedef struct packed {
      logic signed [SAMPLE_W-1:0] sample;
      logic                       restart;
   } req_type;

   typedef struct packed {
      logic signed [SAMPLE_W-1:0] median_value;
      logic [COUNT_OUT_W-1:0]     stored_count;
      logic                       full_drop;
   } rsp_type;

   // What one cell hands to its upper neighbor: its held value and whether it moves up.
   typedef struct packed {
      logic                       shift;
      logic signed [SAMPLE_W-1:0] value;
   } link_type;

endpackage

### hw/rtl/running_median_insertion.sv
// Running median by sorted insertion into a chain of compare-and-shift cells.
// An accepted request is registered into the selection stage (pend_ff), then into the
// response register behind rsp_valid. No new request is taken until the previous one
// has left selection; the chain inserts in the accept cycle and the median tap is
// selected and registered in the following cycle.
// Reset clears the held count and the handshake state and holds req_ready low; the cell
// contents are not reset.
module running_median_insertion #(
   parameter int CAPACITY = 64
) (
   input  logic              clock,
   input  logic              reset,
   input  logic              req_valid,
   output logic              req_ready,
   input  rmi_pkg::req_type  req_payload,
   output logic              rsp_valid,
   input  logic              rsp_ready,
   output rmi_pkg::rsp_type  rsp_payload
);

   localparam int CNT_W = $clog2(CAPACITY + 1);
   localparam int IDX_W = $clog2(CAPACITY);
   localparam logic [CNT_W-1:0] CAP_C = CNT_W'(CAPACITY);
   localparam logic [CNT_W-1:0] ONE_C = CNT_W'(1);

   // Control state.
   logic [CNT_W-1:0] count_ff, count_in;
   logic             pend_ff;
   logic             rsp_valid_ff;
   // Payload held between the insertion cycle and the median selection cycle.
   logic [IDX_W-1:0] mid_ff, mid_in;
   logic             drop_ff;
   rmi_pkg::rsp_type rsp_ff;

   logic                                req_accept;
   logic [CNT_W-1:0]                    count_eff;
   logic                                full;
   logic                                update;
   logic [CNT_W-1:0]                    count_less;
   logic [rmi_pkg::SAMPLE_W-1:0]        median_sel;
   logic [CNT_W+rmi_pkg::COUNT_OUT_W-1:0] count_wide;

   rmi_pkg::link_type                   links [CAPACITY+1];
   logic [rmi_pkg::SAMPLE_W-1:0]        taps  [CAPACITY];

   // A new request is taken once the previous one has left the selection stage and
   // its response is either gone or leaving in this same cycle. Nothing is taken
   // while reset is high.
   assign req_ready  = !reset && !pend_ff && (!rsp_valid_ff || rsp_ready);
   assign req_accept = req_valid && req_ready;

   // A restart empties the store before the sample is placed, so a restarted
   // transaction is never dropped.
   assign count_eff = req_payload.restart ? '0 : count_ff;
   assign full      = count_eff >= CAP_C;
   assign count_in  = full ? count_eff : count_eff + ONE_C;
   assign update    = req_accept && !full;

   // The lower median sits at index (count - 1) / 2 of the sorted chain.
   assign count_less = count_in - ONE_C;
   assign mid_in     = IDX_W'(count_less >> 1);

   // The bottom cell has no lower neighbor: it never receives a shifted value.
   assign links[0].shift = 1'b0;
   assign links[0].value = req_payload.sample;

   for (genvar i = 0; i < CAPACITY; i++) begin : g_cell
      rmi_cell #(
         .INDEX (i),
         .CNT_W (CNT_W),
         .IDX_W (IDX_W)
      ) u_cell (
         .clock      (clock),
         .update     (update),
         .sample     (req_payload.sample),
         .count_eff  (count_eff),
         .mid        (mid_ff),
         .link_left  (links[i]),
         .link_right (links[i+1]),
         .tap        (taps[i])
      );
   end

   // Only the cell addressed by the median index drives a nonzero tap, so an OR
   // across the chain selects its value.
   always_comb begin
      median_sel = '0;
      for (int i = 0; i < CAPACITY; i++) begin
         median_sel = median_sel | taps[i];
      end
   end

   // The reported count is the low seven bits of the held count.
   assign count_wide = {{rmi_pkg::COUNT_OUT_W{1'b0}}, count_ff};

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff     <= '0;
         pend_ff      <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         if (req_accept) begin
            count_ff <= count_in;
         end
         pend_ff <= req_accept;
         if (pend_ff) begin
            rsp_valid_ff <= 1'b1;
         end else if (rsp_ready) begin
            rsp_valid_ff <= 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (req_accept) begin
         mid_ff  <= mid_in;
         drop_ff <= full;
      end
      if (pend_ff) begin
         rsp_ff.median_value <= median_sel;
         rsp_ff.stored_count <= count_wide[rmi_pkg::COUNT_OUT_W-1:0];
         rsp_ff.full_drop    <= drop_ff;
      end
   end

   assign rsp_valid   = rsp_valid_ff;
   assign rsp_payload = rsp_ff;

`ifndef SYNTHESIS
   a_count_bound : assert property (@(posedge clock) disable iff (reset)
      count_ff <= CAP_C)
      else $error("held count exceeds the store capacity");

   a_pend_to_rsp : assert property (@(posedge clock) disable iff (reset)
      pend_ff |=> rsp_valid_ff)
      else $error("selection stage did not produce a response");

   a_no_overlap : assert property (@(posedge clock) disable iff (reset)
      pend_ff |-> !rsp_valid_ff)
      else $error("a transaction entered selection while a response was pending");

   a_drop_full : assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && rsp_ff.full_drop) |-> (count_ff == CAP_C))
      else $error("drop reported while the store is not full");
`endif

endmodule

### hw/rtl/rmi_cell.sv
// One storage cell of the sorted insertion chain.
// Depends on rmi_pkg for the sample width and the neighbor link struct.
module rmi_cell #(
   parameter int INDEX = 0,
   parameter int CNT_W = 7,
   parameter int IDX_W = 6
) (
   input  logic                                 clock,
   input  logic                                 update,
   input  logic signed [rmi_pkg::SAMPLE_W-1:0]  sample,
   input  logic [CNT_W-1:0]                     count_eff,
   input  logic [IDX_W-1:0]                     mid,
   input  rmi_pkg::link_type                    link_left,
   output rmi_pkg::link_type                    link_right,
   output logic [rmi_pkg::SAMPLE_W-1:0]         tap
);

   localparam logic [CNT_W-1:0] IDX_C = CNT_W'(INDEX);
   localparam logic [IDX_W-1:0] IDX_M = IDX_W'(INDEX);

   logic signed [rmi_pkg::SAMPLE_W-1:0] value_ff;
   logic signed [rmi_pkg::SAMPLE_W-1:0] value_in;
   logic                                occupied;
   logic                                shift;

   // An empty cell acts as positive infinity, so it always takes data from below.
   assign occupied = IDX_C < count_eff;
   assign shift    = !occupied || (value_ff > sample);

   always_comb begin
      if (shift) begin
         value_in = link_left.shift ? link_left.value : sample;
      end else begin
         value_in = value_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (update) begin
         value_ff <= value_in;
      end
   end

   assign link_right.shift = shift;
   assign link_right.value = value_ff;
   assign tap = (mid == IDX_M) ? value_ff : '0;

endmodule

### bench/running_median_insertion_tb.sv
// Self-checking testbench for the running median insertion block.
// Depends on rmi_pkg for the request and response structs and on the
// running_median_insertion RTL, which in turn needs rmi_cell.
module running_median_insertion_tb;
   timeunit 1ns;
   timeprecision 1ps;

   // Store depth used for both the instance and the predictor.
   localparam int DEPTH = 64;
   // Cycles with no transaction on either channel before the run is declared hung.
   // The slowest legal gap is the largest send gap plus the largest receive stall
   // plus the pipeline, so this is far beyond any correct run.
   localparam int WATCHDOG_LIMIT = 400;
   // Cycles to keep watching the response channel after the last expected result.
   localparam int TAIL_CYCLES = 8;
   localparam int RANDOM_ITEMS = 625;

   localparam logic signed [rmi_pkg::SAMPLE_W-1:0] MOST_NEG = 32'sh8000_0000;
   localparam logic signed [rmi_pkg::SAMPLE_W-1:0] MOST_POS = 32'sh7FFF_FFFF;

   // The predictor keeps its own sorted copy of the samples and queues the result that
   // each accepted request transaction should produce; responses are checked in order.
   class median_scoreboard;
      logic signed [rmi_pkg::SAMPLE_W-1:0] ordered[DEPTH];
      int unsigned                         fill;
      rmi_pkg::rsp_type                    expected_q[$];
      int unsigned                         failures;

      function new();
         fill = 0;
         failures = 0;
      endfunction

      function void note_request(rmi_pkg::req_type item);
         logic signed [rmi_pkg::SAMPLE_W-1:0] incoming;
         rmi_pkg::rsp_type                    want;
         int unsigned                         pos;
         int unsigned                         mid;
         incoming = item.sample;
         want.full_drop = 1'b0;
         if (item.restart) begin
            fill = 0;
         end
         if (fill >= DEPTH) begin
            want.full_drop = 1'b1;
         end else begin
            // Walk down from the top, moving every strictly greater entry up one slot,
            // so that a new sample lands after any equal ones already held.
            pos = fill;
            while (pos > 0 && ordered[pos-1] > incoming) begin
               ordered[pos] = ordered[pos-1];
               pos--;
            end
            ordered[pos] = incoming;
            fill++;
         end
         mid = (fill - 1) / 2;
         want.median_value = ordered[mid];
         want.stored_count = fill[rmi_pkg::COUNT_OUT_W-1:0];
         expected_q.push_back(want);
      endfunction

      function void check_response(rmi_pkg::rsp_type got);
         rmi_pkg::rsp_type want;
         if (expected_q.size() == 0) begin
            failures++;
            $display("%0t: unexpected response, expected none, got median %0d",
                     $time, got.median_value);
            $display("%0t: unexpected response count %0d drop %0b",
                     $time, got.stored_count, got.full_drop);
            return;
         end
         want = expected_q.pop_front();
         if (got.median_value !== want.median_value) begin
            failures++;
            $display("%0t: median_value expected %0d, got %0d",
                     $time, want.median_value, got.median_value);
         end
         if (got.stored_count !== want.stored_count) begin
            failures++;
            $display("%0t: stored_count expected %0d, got %0d",
                     $time, want.stored_count, got.stored_count);
         end
         if (got.full_drop !== want.full_drop) begin
            failures++;
            $display("%0t: full_drop expected %0b, got %0b",
                     $time, want.full_drop, got.full_drop);
         end
      endfunction

      function int unsigned outstanding();
         return expected_q.size();
      endfunction
   endclass

   logic             clock;
   logic             reset = 1'b1;
   logic             req_valid = 1'b0;
   logic             req_ready;
   rmi_pkg::req_type req_payload = '0;
   logic             rsp_valid;
   logic             rsp_ready = 1'b0;
   rmi_pkg::rsp_type rsp_payload;

   median_scoreboard sb;
   int unsigned      idle_cycles = 0;
   // When set, the matching side stops idling, giving back-to-back stretches.
   bit               quiet_tx = 1'b0;
   bit               quiet_rx = 1'b0;

   running_median_insertion #(
      .CAPACITY(DEPTH)
   ) u_top (
      .clock(clock),
      .reset(reset),
      .req_valid(req_valid),
      .req_ready(req_ready),
      .req_payload(req_payload),
      .rsp_valid(rsp_valid),
      .rsp_ready(rsp_ready),
      .rsp_payload(rsp_payload)
   );

   initial begin
      clock = 1'b0;
      forever #6 clock = ~clock;
   end

   function automatic rmi_pkg::req_type make_request(
      logic signed [rmi_pkg::SAMPLE_W-1:0] value,
      logic                                restart
   );
      rmi_pkg::req_type item;
      item.sample = value;
      item.restart = restart;
      return item;
   endfunction

   // Sample values are a mix of full-range words, the two extremes and their
   // neighbors, and a narrow band around zero that produces many equal values.
   function automatic logic signed [rmi_pkg::SAMPLE_W-1:0] pick_sample();
      logic signed [rmi_pkg::SAMPLE_W-1:0] value;
      case ($urandom_range(0, 9))
         0: begin
            value = ($urandom_range(0, 1) != 0) ? MOST_NEG + $urandom_range(0, 3)
                                                : MOST_POS - $urandom_range(0, 3);
         end
         1, 2, 3: begin
            value = $urandom_range(0, 20) - 10;
         end
         default: begin
            value = $urandom;
         end
      endcase
      return value;
   endfunction

   // Presents one request transaction after a random gap and returns at the edge where
   // it is taken. Valid is left high so that a zero gap gives back-to-back transactions.
   task automatic send_request(rmi_pkg::req_type item);
      int unsigned gap;
      if ($urandom_range(0, 29) == 0) begin
         quiet_tx = !quiet_tx;
      end
      gap = quiet_tx ? 0 : $urandom_range(0, 15);
      if (gap > 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_payload <= item;
      req_valid <= 1'b1;
      do begin
         @(posedge clock);
      end while (!req_ready);
      sb.note_request(item);
   endtask

   // Drops valid and holds off until every predicted result has been received.
   task automatic wait_for_drain();
      req_valid <= 1'b0;
      while (sb.outstanding() != 0) @(posedge clock);
   endtask

   // Short directed sequence: the first sample lands in an empty store without a restart,
   // then the extremes, repeated equal values, back-to-back restarts and alternating bits.
   task automatic run_directed();
      send_request(make_request(5, 1'b0));
      send_request(make_request(MOST_POS, 1'b0));
      send_request(make_request(MOST_NEG, 1'b0));
      send_request(make_request(0, 1'b0));
      send_request(make_request(-1, 1'b0));
      send_request(make_request(1, 1'b0));
      send_request(make_request(5, 1'b0));
      send_request(make_request(5, 1'b0));
      send_request(make_request(MOST_NEG, 1'b0));
      send_request(make_request(MOST_POS, 1'b0));
      send_request(make_request(MOST_POS, 1'b0));
      send_request(make_request(-7, 1'b1));
      send_request(make_request(3, 1'b0));
      send_request(make_request(-7, 1'b0));
      send_request(make_request(MOST_NEG + 1, 1'b0));
      send_request(make_request(MOST_POS - 1, 1'b0));
      send_request(make_request(0, 1'b1));
      send_request(make_request(0, 1'b1));
      send_request(make_request(-100, 1'b0));
      send_request(make_request(100, 1'b0));
      send_request(make_request(32'sh5555_5555, 1'b0));
      send_request(make_request(32'shAAAA_AAAA, 1'b0));
   endtask

   // Random traffic is organized as runs that normally open with a restart. Most runs are
   // short, but about one in four is long enough to fill the store and keep pushing
   // samples that must be dropped; the run after such a run restarts a full store.
   // A stray restart inside a run and a run that skips its restart act as noise.
   task automatic run_random();
      int unsigned sent;
      int unsigned run_len;
      int unsigned k;
      logic        restart;
      bit          first_run;
      sent = 0;
      first_run = 1'b1;
      while (sent < RANDOM_ITEMS) begin
         if (first_run) begin
            run_len = 70;
         end else if ($urandom_range(0, 3) == 0) begin
            run_len = $urandom_range(60, 90);
         end else begin
            run_len = $urandom_range(1, 40);
         end
         for (k = 0; k < run_len && sent < RANDOM_ITEMS; k++) begin
            if (k == 0) begin
               restart = ($urandom_range(0, 7) != 0);
            end else begin
               restart = ($urandom_range(0, 59) == 0);
            end
            send_request(make_request(pick_sample(), restart));
            sent++;
         end
         first_run = 1'b0;
         if ($urandom_range(0, 5) == 0) begin
            wait_for_drain();
         end
      end
   endtask

   // Stimulus and end of test.
   initial begin
      sb = new();
      repeat (8) @(posedge clock);
      reset <= 1'b0;
      run_directed();
      wait_for_drain();
      run_random();
      wait_for_drain();
      repeat (TAIL_CYCLES) @(posedge clock);
      if (sb.failures == 0) begin
         $display("[running_median_insertion] OK");
      end else begin
         $display("[running_median_insertion] ERROR");
      end
      $finish;
   end

   // Response side: stalls a random number of cycles before each transaction, then
   // holds ready until one is taken and checks it against the oldest prediction.
   initial begin
      int unsigned stall;
      while (reset) @(posedge clock);
      forever begin
         if ($urandom_range(0, 29) == 0) begin
            quiet_rx = !quiet_rx;
         end
         stall = quiet_rx ? 0 : $urandom_range(0, 15);
         if (stall > 0) begin
            rsp_ready <= 1'b0;
            repeat (stall) @(posedge clock);
         end
         rsp_ready <= 1'b1;
         do begin
            @(posedge clock);
         end while (!rsp_valid);
         sb.check_response(rsp_payload);
      end
   end

   // Watchdog: a hung handshake or a result that never arrives ends the run here.
   initial begin
      while (idle_cycles < WATCHDOG_LIMIT) begin
         @(posedge clock);
         if (reset || (req_valid && req_ready) || (rsp_valid && rsp_ready)) begin
            idle_cycles = 0;
         end else begin
            idle_cycles++;
         end
      end
      $display("%0t: no transaction for %0d cycles, %0d results still expected",
               $time, WATCHDOG_LIMIT, sb.outstanding());
      $display("[running_median_insertion] ERROR");
      $finish;
   end

endmodule

### sim.f
hw/rtl/rmi_pkg.sv
hw/rtl/rmi_cell.sv
hw/rtl/running_median_insertion.sv
bench/running_median_insertion_tb.sv
